FILE: rtl/core/lcbf_pkg.sv
// lcbf_pkg: shared constants, codes and types of the line counting byte fifo
// depends on nothing; imported by lcbf_mem, lcbf_ctrl and line_counting_byte_fifo
package lcbf_pkg;

  localparam int DEPTH        = 4096;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int OUT_FILL_W   = 12;
  localparam int FILL_W       = (ADDR_W > OUT_FILL_W) ? ADDR_W : OUT_FILL_W;
  localparam int MAX_RESULTS  = 64;
  localparam int CNT_W        = 7;
  localparam int BYTE_W       = 8;
  localparam int LINE_W       = 8;
  localparam int ACTION_W     = 2;
  localparam int STATUS_W     = 3;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE      = 8'h0A;
  localparam logic [LINE_W-1:0] LINE_LIMIT_RESET  = 8'd10;
  localparam logic [LINE_W-1:0] LINE_COUNT_MAX    = 8'd255;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH      = 2'd0,
    ACT_POP       = 2'd1,
    ACT_READ_LINE = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_NO_SPACE   = 3'd1,
    STAT_LINE_LIMIT = 3'd2,
    STAT_EMPTY      = 3'd3,
    STAT_NO_NEWLINE = 3'd4
  } status_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                  valid;
    logic [BYTE_W-1:0]     data;
    status_t               status;
    logic                  last;
    logic [LINE_W-1:0]     lines;
    logic [OUT_FILL_W-1:0] fill;
  } result_t;

  // next slot on the ring
  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] r;
    if (p == ADDR_W'(DEPTH - 1)) r = '0;
    else r = p + ADDR_W'(1);
    return r;
  endfunction

  // bytes held between the pointers
  function automatic logic [FILL_W-1:0] fill_of(input logic [ADDR_W-1:0] wp,
                                                input logic [ADDR_W-1:0] rp,
                                                input logic              empty);
    logic [FILL_W-1:0] r;
    if (empty) r = '0;
    else if (wp >= rp) r = FILL_W'(wp) - FILL_W'(rp);
    else r = FILL_W'(wp) + FILL_W'(DEPTH) - FILL_W'(rp);
    return r;
  endfunction

endpackage

FILE: rtl/core/line_counting_byte_fifo.sv
// line_counting_byte_fifo: top level with the line limit register and the fifo core
// depends on lcbf_pkg, lcbf_mem and lcbf_ctrl
//
// Circular byte fifo of DEPTH slots (one always free) that counts the newline
// bytes it holds. An item is taken when start is high and busy is low; every
// result beat shows on the result ports for exactly one cycle with result_valid
// high and cannot be held off by the receiver. A push, action 3 and a pop or
// line read on an empty fifo answer one beat in the cycle after the item and
// leave busy low, so these run at one item per cycle. A pop keeps busy high
// while it streams its bytes, one byte per cycle, through the registered read
// of the byte store and the result register; the next item can go in once busy
// falls. A line read first scans the store one byte per cycle up to the first
// newline or the clamped length, then replays from the read pointer, one beat
// per cycle. This pace is set by the single read port of the byte store, whose
// read data is registered. There is no clearing pass after reset. The line
// limit is written through cfg_valid/cfg_ready (always ready) and must only
// change while idle.
module line_counting_byte_fifo (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [lcbf_pkg::ACTION_W-1:0]       action,
  input  logic [lcbf_pkg::BYTE_W-1:0]         data_in,
  input  logic [lcbf_pkg::CNT_W-1:0]          max_length,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcbf_pkg::LINE_W-1:0]         cfg_data,
  output logic                                result_valid,
  output logic [lcbf_pkg::BYTE_W-1:0]         data_out,
  output logic [lcbf_pkg::STATUS_W-1:0]       status,
  output logic                                last,
  output logic [lcbf_pkg::LINE_W-1:0]         lines_queued,
  output logic [lcbf_pkg::OUT_FILL_W-1:0]     bytes_stored
);
  import lcbf_pkg::*;

  logic [LINE_W-1:0] line_limit;
  mem_req_t          mem_req;
  logic [BYTE_W-1:0] rd_data;
  result_t           res;

  // config beats are taken at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LINE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      line_limit <= cfg_data;
    end
  end

  // byte store
  lcbf_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // pointers, line counter, request sequencer and result register
  lcbf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .data_in    (data_in),
    .max_length (max_length),
    .line_limit (line_limit),
    .mem_req    (mem_req),
    .rd_data    (rd_data),
    .res        (res)
  );

  // result beat to the ports
  assign result_valid = res.valid;
  assign data_out     = res.data;
  assign status       = res.status;
  assign last         = res.last;
  assign lines_queued = res.lines;
  assign bytes_stored = res.fill;

endmodule

FILE: rtl/core/lcbf_mem.sv
// lcbf_mem: byte store of the fifo, one write and one read port, registered read data
// depends on lcbf_pkg
module lcbf_mem (
  input  logic                              clk,
  input  lcbf_pkg::mem_req_t                req,
  output logic [lcbf_pkg::BYTE_W-1:0]       rd_data
);
  import lcbf_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

FILE: rtl/core/lcbf_ctrl.sv
// lcbf_ctrl: pointers, line counter and the request sequencer of the fifo
// depends on lcbf_pkg; drives lcbf_mem through a mem_req_t
module lcbf_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [lcbf_pkg::ACTION_W-1:0]     action,
  input  logic [lcbf_pkg::BYTE_W-1:0]       data_in,
  input  logic [lcbf_pkg::CNT_W-1:0]        max_length,
  input  logic [lcbf_pkg::LINE_W-1:0]       line_limit,
  output lcbf_pkg::mem_req_t                mem_req,
  input  logic [lcbf_pkg::BYTE_W-1:0]       rd_data,
  output lcbf_pkg::result_t                 res
);
  import lcbf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_STREAM} state_t;

  state_t            state, state_next;
  logic [ADDR_W-1:0] rp, rp_next;
  logic [ADDR_W-1:0] wp, wp_next;
  logic              empty_f, empty_f_next;
  logic [LINE_W-1:0] lc, lc_next;
  logic [ADDR_W-1:0] cur, cur_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic              consume, consume_next;
  result_t           res_next;

  logic [FILL_W-1:0] fill_now;
  logic [CNT_W-1:0]  len_c;
  logic [CNT_W-1:0]  n_take;
  logic              is_last;

  assign busy     = (state != S_IDLE);
  assign fill_now = fill_of(wp, rp, empty_f);
  assign is_last  = (idx + CNT_W'(1) == cnt);

  // clamp the requested length to 1..64, then to the bytes held
  always_comb begin
    if (max_length == '0) len_c = CNT_W'(1);
    else if (max_length > CNT_W'(MAX_RESULTS)) len_c = CNT_W'(MAX_RESULTS);
    else len_c = max_length;
    if (FILL_W'(len_c) < fill_now) n_take = len_c;
    else n_take = CNT_W'(fill_now);
  end

  always_comb begin
    logic [ADDR_W-1:0] nxt;
    state_next   = state;
    rp_next      = rp;
    wp_next      = wp;
    empty_f_next = empty_f;
    lc_next      = lc;
    cur_next     = cur;
    cnt_next     = cnt;
    idx_next     = idx;
    consume_next = consume;
    mem_req      = '0;
    res_next     = res;
    res_next.valid = 1'b0;
    nxt          = ptr_inc(cur);

    case (state)
      S_IDLE: begin
        if (start) begin
          res_next.data = '0;
          res_next.last = 1'b1;
          res_next.status = STAT_OK;
          case (action)
            ACT_PUSH: begin
              if (data_in == NEWLINE_BYTE &&
                  ({1'b0, lc} + 9'd1) > {1'b0, line_limit}) begin
                res_next.status = STAT_LINE_LIMIT;
              end else if (fill_now >= FILL_W'(DEPTH - 1)) begin
                res_next.status = STAT_NO_SPACE;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = wp;
                mem_req.wdata = data_in;
                wp_next       = ptr_inc(wp);
                empty_f_next  = 1'b0;
                if (data_in == NEWLINE_BYTE && lc < LINE_COUNT_MAX) begin
                  lc_next = lc + LINE_W'(1);
                end
              end
              res_next.valid = 1'b1;
            end
            ACT_POP, ACT_READ_LINE: begin
              if (empty_f) begin
                res_next.status = STAT_EMPTY;
                res_next.valid  = 1'b1;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = rp;
                cur_next      = rp;
                cnt_next      = n_take;
                idx_next      = '0;
                consume_next  = 1'b1;
                state_next    = (action == ACT_POP) ? S_STREAM : S_SCAN;
              end
            end
            default: begin
              res_next.valid = 1'b1;
            end
          endcase
        end
      end

      // look for the first newline up to the clamped length; then replay from the read pointer
      S_SCAN: begin
        if (rd_data == NEWLINE_BYTE || is_last) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rp;
          cur_next      = rp;
          idx_next      = '0;
          state_next    = S_STREAM;
          if (rd_data == NEWLINE_BYTE) begin
            cnt_next     = idx + CNT_W'(1);
            consume_next = 1'b1;
          end else begin
            consume_next = 1'b0;
          end
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = nxt;
          cur_next      = nxt;
          idx_next      = idx + CNT_W'(1);
        end
      end

      S_STREAM: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = nxt;
        cur_next      = nxt;
        idx_next      = idx + CNT_W'(1);
        res_next.valid  = 1'b1;
        res_next.data   = rd_data;
        res_next.last   = is_last;
        res_next.status = STAT_OK;
        if (consume) begin
          rp_next = nxt;
          if (rd_data == NEWLINE_BYTE && lc != '0) begin
            lc_next = lc - LINE_W'(1);
          end
          if (nxt == wp) begin
            empty_f_next = 1'b1;
          end
        end else if (is_last) begin
          res_next.status = STAT_NO_NEWLINE;
        end
        if (is_last) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    res_next.lines = lc_next;
    res_next.fill  = OUT_FILL_W'(fill_of(wp_next, rp_next, empty_f_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rp        <= '0;
      wp        <= '0;
      empty_f   <= 1'b1;
      lc        <= '0;
      res.valid <= 1'b0;
    end else begin
      state     <= state_next;
      rp        <= rp_next;
      wp        <= wp_next;
      empty_f   <= empty_f_next;
      lc        <= lc_next;
      res.valid <= res_next.valid;
    end
    cur        <= cur_next;
    cnt        <= cnt_next;
    idx        <= idx_next;
    consume    <= consume_next;
    res.data   <= res_next.data;
    res.status <= res_next.status;
    res.last   <= res_next.last;
    res.lines  <= res_next.lines;
    res.fill   <= res_next.fill;
  end

  // store writes only from idle, so a read never meets a write in flight
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !mem_req.we)
    else $error("byte store written while a request is in progress");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    empty_f |-> (rp == wp))
    else $error("empty flag set with pointers apart");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.last) |-> (state == S_IDLE))
    else $error("final beat of a request while the sequencer is still busy");

  a_peek_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == S_STREAM && !consume) |=> (lc == $past(lc) && rp == $past(rp)))
    else $error("replay of a line without newline consumed bytes");

  a_fill_room: assert property (@(posedge clk) disable iff (rst)
    fill_now <= FILL_W'(DEPTH - 1))
    else $error("fill level beyond the free slot rule");

endmodule
